### rtl/rce_pkg.sv
// Shared types, constants and table helpers for the rotor cipher encrypt block.
// Used by every module under rtl/. No dependencies.
package rce_pkg;

  localparam int unsigned DefAlphabetSize = 26;
  localparam int unsigned SymW            = 5;
  localparam int unsigned SelW            = 3;
  localparam int unsigned NumTables       = 8;
  localparam int unsigned NumLookups      = 9;
  localparam int unsigned LkpW            = 4;
  localparam logic [LkpW-1:0] LastLkp     = LkpW'(NumLookups - 1);

  localparam logic [SelW-1:0] TblRot0Fwd = 3'd0;
  localparam logic [SelW-1:0] TblRot0Bwd = 3'd1;
  localparam logic [SelW-1:0] TblRot1Fwd = 3'd2;
  localparam logic [SelW-1:0] TblRot1Bwd = 3'd3;
  localparam logic [SelW-1:0] TblRot2Fwd = 3'd4;
  localparam logic [SelW-1:0] TblRot2Bwd = 3'd5;
  localparam logic [SelW-1:0] TblRefl    = 3'd6;
  localparam logic [SelW-1:0] TblPlug    = 3'd7;

  typedef enum logic [1:0] {
    ModeEncrypt = 2'd0,
    ModeLoad    = 2'd1,
    ModeSetPos  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RotFast   = 2'd0,
    RotMiddle = 2'd1,
    RotSlow   = 2'd2,
    RotNone   = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    SeqIdle,
    SeqLook,
    SeqData,
    SeqDone
  } seq_e;

  typedef struct packed {
    logic            in_ready;
    logic            look;
    logic            data;
    logic            out_load;
    logic [LkpW-1:0] lkp;
  } seq_ctrl_t;

  // x mod a for every 5-bit x, built by a wrapping counter
  function automatic logic [31:0][SymW-1:0] mod_table(int unsigned a);
    logic [31:0][SymW-1:0] t;
    logic [SymW-1:0]       r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      t[i] = r;
      if (int'(r) + 1 >= int'(a)) begin
        r = '0;
      end else begin
        r = r + SymW'(1);
      end
    end
    return t;
  endfunction

  // table used at each lookup of the letter path
  function automatic logic [SelW-1:0] lkp_table(logic [LkpW-1:0] k);
    logic [SelW-1:0] s;
    case (k)
      4'd1:    s = TblRot0Fwd;
      4'd2:    s = TblRot1Fwd;
      4'd3:    s = TblRot2Fwd;
      4'd4:    s = TblRefl;
      4'd5:    s = TblRot2Bwd;
      4'd6:    s = TblRot1Bwd;
      4'd7:    s = TblRot0Bwd;
      default: s = TblPlug;
    endcase
    return s;
  endfunction

  function automatic rot_e lkp_rotor(logic [LkpW-1:0] k);
    rot_e r;
    case (k)
      4'd1, 4'd7: r = RotFast;
      4'd2, 4'd6: r = RotMiddle;
      4'd3, 4'd5: r = RotSlow;
      default:    r = RotNone;
    endcase
    return r;
  endfunction

endpackage

### rtl/rotor_cipher_encrypt_top.sv
// Top level of the three-rotor letter cipher: datapath, positions, output register.
// Depends on rce_pkg, rce_mod_unit, rce_tbl_mem, rce_seq.
//
//   channel | signals                          | direction | payload
//   in      | in_valid_i / in_ready_o          | input     | mode, letter, table, positions
//   out     | out_valid_o / out_ready_i        | output    | cipher_letter
//
// Load and set-position items complete on acceptance and the input stays ready. An
// encrypt item makes nine lookups through the shared table memory after the accept,
// each a look step (address through the shared mod unit) then a data step (registered
// read data back through it), and then loads the result.
// Reset clears the rotor positions and the sequencer; tables are undefined until loaded.
// A held output stalls the sequencer in its final state; in_ready_o stays low meanwhile.
module rotor_cipher_encrypt_top #(
  parameter int unsigned ALPHABET_SIZE = rce_pkg::DefAlphabetSize
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [rce_pkg::SymW-1:0] letter_i,
  input  logic [rce_pkg::SelW-1:0] table_select_i,
  input  logic [rce_pkg::SymW-1:0] table_index_i,
  input  logic [rce_pkg::SymW-1:0] table_value_i,
  input  logic [rce_pkg::SymW-1:0] pos_fast_i,
  input  logic [rce_pkg::SymW-1:0] pos_middle_i,
  input  logic [rce_pkg::SymW-1:0] pos_slow_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [rce_pkg::SymW-1:0] cipher_letter_o
);

  localparam int unsigned IdxW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned AddrW = $clog2(rce_pkg::NumTables * ALPHABET_SIZE);
  localparam logic [31:0][rce_pkg::SymW-1:0] ModTbl = rce_pkg::mod_table(ALPHABET_SIZE);
  localparam logic [IdxW-1:0]   LastPos = IdxW'(ALPHABET_SIZE - 1);
  localparam logic [IdxW:0]     Lim     = (IdxW+1)'(ALPHABET_SIZE);
  localparam logic [AddrW-1:0]  TblSpan = AddrW'(ALPHABET_SIZE);

  rce_pkg::seq_ctrl_t ctrl;
  rce_pkg::mode_e     mode;
  logic               accept;
  logic               out_free;

  logic [IdxW-1:0] v_q, v_d;
  logic [IdxW-1:0] pos_q [3];
  logic [IdxW-1:0] pos_d [3];
  logic            out_valid_q;
  logic [IdxW-1:0] cipher_q;

  logic [IdxW-1:0]          pos_sel;
  logic [IdxW-1:0]          unit_a;
  logic [IdxW-1:0]          unit_y;
  logic [rce_pkg::SymW-1:0] rdata;
  logic [IdxW-1:0]          rdata_red;
  logic [AddrW-1:0]         raddr;
  logic [AddrW-1:0]         waddr;
  logic                     we;

  assign mode       = rce_pkg::mode_e'(mode_i);
  assign in_ready_o = ctrl.in_ready;
  assign accept     = in_valid_i && ctrl.in_ready;
  assign out_free   = !out_valid_q || out_ready_i;

  rce_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .encrypt_i  (mode == rce_pkg::ModeEncrypt),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    case (rce_pkg::lkp_rotor(ctrl.lkp))
      rce_pkg::RotFast:   pos_sel = pos_q[0];
      rce_pkg::RotMiddle: pos_sel = pos_q[1];
      rce_pkg::RotSlow:   pos_sel = pos_q[2];
      default:            pos_sel = '0;
    endcase
  end

  assign rdata_red = ModTbl[rdata][IdxW-1:0];
  assign unit_a    = ctrl.data ? rdata_red : v_q;

  rce_mod_unit #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_unit (
    .sub_i (ctrl.data),
    .a_i   (unit_a),
    .b_i   (pos_sel),
    .y_o   (unit_y)
  );

  assign raddr = AddrW'(rce_pkg::lkp_table(ctrl.lkp)) * TblSpan + AddrW'(unit_y);
  assign waddr = AddrW'(table_select_i) * TblSpan + AddrW'(table_index_i);
  assign we    = accept && (mode == rce_pkg::ModeLoad) && ({1'b0, table_index_i} < 6'(ALPHABET_SIZE));

  rce_tbl_mem #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (table_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    v_d   = v_q;
    pos_d = pos_q;
    if (accept && (mode == rce_pkg::ModeEncrypt)) begin
      v_d = ModTbl[letter_i][IdxW-1:0];
      // base-N odometer, fast rotor first
      if (pos_q[0] == LastPos) begin
        pos_d[0] = '0;
        if (pos_q[1] == LastPos) begin
          pos_d[1] = '0;
          pos_d[2] = (pos_q[2] == LastPos) ? '0 : pos_q[2] + IdxW'(1);
        end else begin
          pos_d[1] = pos_q[1] + IdxW'(1);
        end
      end else begin
        pos_d[0] = pos_q[0] + IdxW'(1);
      end
    end else if (accept && (mode == rce_pkg::ModeSetPos)) begin
      pos_d[0] = ModTbl[pos_fast_i][IdxW-1:0];
      pos_d[1] = ModTbl[pos_middle_i][IdxW-1:0];
      pos_d[2] = ModTbl[pos_slow_i][IdxW-1:0];
    end else if (ctrl.data) begin
      v_d = unit_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (ctrl.out_load) begin
      cipher_q <= v_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_letter_o = rce_pkg::SymW'(cipher_q);

  a_encrypt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == rce_pkg::ModeEncrypt) |=> !in_ready_o)
    else $error("ready high right after an encrypt item");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pos_q[0]} < Lim) && ({1'b0, pos_q[1]} < Lim) && ({1'b0, pos_q[2]} < Lim))
    else $error("rotor position out of range");

  a_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.data |=> ({1'b0, v_q} < Lim))
    else $error("letter path value out of range");

  a_lkp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.look || ctrl.data) |-> (ctrl.lkp <= rce_pkg::LastLkp))
    else $error("lookup counter out of range");

endmodule

### rtl/rce_mod_unit.sv
// Shared modular add/subtract unit: (a + b) or (a - b) mod ALPHABET_SIZE.
// Operands are already below ALPHABET_SIZE. Depends on rce_pkg.
module rce_mod_unit #(
  parameter int unsigned ALPHABET_SIZE = rce_pkg::DefAlphabetSize,
  localparam int unsigned IdxW = $clog2(ALPHABET_SIZE)
) (
  input  logic            sub_i,
  input  logic [IdxW-1:0] a_i,
  input  logic [IdxW-1:0] b_i,
  output logic [IdxW-1:0] y_o
);

  localparam int unsigned SumW = IdxW + 1;
  localparam logic [SumW-1:0] Modulus = SumW'(ALPHABET_SIZE);

  logic [SumW-1:0] b_ext;
  logic [SumW-1:0] sum;

  always_comb begin
    b_ext = sub_i ? (Modulus - {1'b0, b_i}) : {1'b0, b_i};
    sum   = {1'b0, a_i} + b_ext;
    if (sum >= Modulus) begin
      sum = sum - Modulus;
    end
  end

  assign y_o = sum[IdxW-1:0];

endmodule

### rtl/rce_tbl_mem.sv
// Single table memory holding rotor, reflector and plugboard tables.
// One write port, one registered read port. Depends on rce_pkg.
module rce_tbl_mem #(
  parameter int unsigned ALPHABET_SIZE = rce_pkg::DefAlphabetSize,
  localparam int unsigned Depth = rce_pkg::NumTables * ALPHABET_SIZE,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [rce_pkg::SymW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [rce_pkg::SymW-1:0] rdata_o
);

  logic [rce_pkg::SymW-1:0] mem [Depth];
  logic [rce_pkg::SymW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rce_seq.sv
// Sequencer for one encrypt item: nine table lookups, each a look state then a data state.
// Depends on rce_pkg.
module rce_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               encrypt_i,
  input  logic               out_free_i,
  output rce_pkg::seq_ctrl_t ctrl_o
);

  rce_pkg::seq_e             state_q, state_d;
  logic [rce_pkg::LkpW-1:0]  lkp_q, lkp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rce_pkg::SeqIdle;
      lkp_q   <= '0;
    end else begin
      state_q <= state_d;
      lkp_q   <= lkp_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    lkp_d           = lkp_q;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.look     = 1'b0;
    ctrl_o.data     = 1'b0;
    ctrl_o.out_load = 1'b0;
    ctrl_o.lkp      = lkp_q;
    case (state_q)
      rce_pkg::SeqIdle: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i && encrypt_i) begin
          lkp_d   = '0;
          state_d = rce_pkg::SeqLook;
        end
      end
      rce_pkg::SeqLook: begin
        ctrl_o.look = 1'b1;
        state_d     = rce_pkg::SeqData;
      end
      rce_pkg::SeqData: begin
        ctrl_o.data = 1'b1;
        if (lkp_q == rce_pkg::LastLkp) begin
          state_d = rce_pkg::SeqDone;
        end else begin
          lkp_d   = lkp_q + rce_pkg::LkpW'(1);
          state_d = rce_pkg::SeqLook;
        end
      end
      rce_pkg::SeqDone: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = rce_pkg::SeqIdle;
        end
      end
      default: begin
        state_d = rce_pkg::SeqIdle;
      end
    endcase
  end

endmodule

### bench/rce_checker.sv
// Scoreboard for rotor_cipher_encrypt_top: mirrors tables and rotor positions,
// predicts each cipher letter and compares it in order. Depends on rce_pkg.
module rce_checker #(
  parameter int unsigned ALPHABET_SIZE = rce_pkg::DefAlphabetSize
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               mode_i,
  input  logic [rce_pkg::SymW-1:0] letter_i,
  input  logic [rce_pkg::SelW-1:0] table_select_i,
  input  logic [rce_pkg::SymW-1:0] table_index_i,
  input  logic [rce_pkg::SymW-1:0] table_value_i,
  input  logic [rce_pkg::SymW-1:0] pos_fast_i,
  input  logic [rce_pkg::SymW-1:0] pos_middle_i,
  input  logic [rce_pkg::SymW-1:0] pos_slow_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [rce_pkg::SymW-1:0] cipher_letter_i,
  output int                       fail_count_o,
  output int                       due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Alpha = int'(ALPHABET_SIZE);

  logic [rce_pkg::SymW-1:0] rotor_map [6][Alpha];
  logic [rce_pkg::SymW-1:0] refl_map  [Alpha];
  logic [rce_pkg::SymW-1:0] plug_map  [Alpha];
  logic [rce_pkg::SymW-1:0] rotor_pos [3];
  logic [rce_pkg::SymW-1:0] cipher_due [$];
  int                       fails = 0;

  function automatic logic [rce_pkg::SymW-1:0] through_rotor(logic [rce_pkg::SymW-1:0] v,
                                                             int r, int dir);
    int p;
    int s;
    int t;
    p = int'(rotor_pos[r]);
    s = (int'(v) + p) % Alpha;
    t = int'(rotor_map[2 * r + dir][s]) % Alpha;
    return rce_pkg::SymW'((t + Alpha - p) % Alpha);
  endfunction

  function automatic void step_positions();
    for (int r = 0; r < 3; r++) begin
      if (int'(rotor_pos[r]) + 1 < Alpha) begin
        rotor_pos[r] = rotor_pos[r] + rce_pkg::SymW'(1);
        return;
      end
      rotor_pos[r] = '0;
    end
  endfunction

  function automatic logic [rce_pkg::SymW-1:0] encipher_letter(
    logic [rce_pkg::SymW-1:0] plain);
    logic [rce_pkg::SymW-1:0] v;
    step_positions();
    v = rce_pkg::SymW'(int'(plug_map[int'(plain) % Alpha]) % Alpha);
    for (int r = 0; r < 3; r++) v = through_rotor(v, r, 0);
    v = rce_pkg::SymW'(int'(refl_map[v]) % Alpha);
    for (int r = 2; r >= 0; r--) v = through_rotor(v, r, 1);
    v = rce_pkg::SymW'(int'(plug_map[v]) % Alpha);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [rce_pkg::SymW-1:0] want;
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) rotor_pos[r] = '0;
      cipher_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cipher_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected cipher letter %0d", cipher_letter_i);
          end
        end else begin
          want = cipher_due.pop_front();
          if (cipher_letter_i !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("cipher letter mismatch: expected %0d, got %0d", want, cipher_letter_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          rce_pkg::ModeEncrypt: begin
            cipher_due.push_back(encipher_letter(letter_i));
          end
          rce_pkg::ModeLoad: begin
            if (int'(table_index_i) < Alpha) begin
              if (table_select_i == rce_pkg::TblPlug) begin
                plug_map[table_index_i] = table_value_i;
              end else if (table_select_i == rce_pkg::TblRefl) begin
                refl_map[table_index_i] = table_value_i;
              end else begin
                rotor_map[table_select_i][table_index_i] = table_value_i;
              end
            end
          end
          rce_pkg::ModeSetPos: begin
            rotor_pos[0] = rce_pkg::SymW'(int'(pos_fast_i) % Alpha);
            rotor_pos[1] = rce_pkg::SymW'(int'(pos_middle_i) % Alpha);
            rotor_pos[2] = rce_pkg::SymW'(int'(pos_slow_i) % Alpha);
          end
          default: begin
          end
        endcase
      end
    end
    fail_count_o <= fails;
    due_count_o  <= cipher_due.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top for rotor_cipher_encrypt_top: loads every table, then runs directed
// and random items with bursty input and stalling output. Depends on rce_pkg, rce_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AlphaSize = rce_pkg::DefAlphabetSize;
  localparam int Alpha = int'(AlphaSize);
  localparam logic [1:0] ModeUnused = 2'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               mode_i = '0;
  logic [rce_pkg::SymW-1:0] letter_i = '0;
  logic [rce_pkg::SelW-1:0] table_select_i = '0;
  logic [rce_pkg::SymW-1:0] table_index_i = '0;
  logic [rce_pkg::SymW-1:0] table_value_i = '0;
  logic [rce_pkg::SymW-1:0] pos_fast_i = '0;
  logic [rce_pkg::SymW-1:0] pos_middle_i = '0;
  logic [rce_pkg::SymW-1:0] pos_slow_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [rce_pkg::SymW-1:0] cipher_letter_o;

  int fail_count;
  int due_count;
  int burst_left = 0;
  int stall_left = 0;
  int stall_style = 0;
  int cyc = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rotor_cipher_encrypt_top #(
    .ALPHABET_SIZE(AlphaSize)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .letter_i       (letter_i),
    .table_select_i (table_select_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .pos_fast_i     (pos_fast_i),
    .pos_middle_i   (pos_middle_i),
    .pos_slow_i     (pos_slow_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cipher_letter_o(cipher_letter_o)
  );

  rce_checker #(
    .ALPHABET_SIZE(AlphaSize)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .mode_i         (mode_i),
    .letter_i       (letter_i),
    .table_select_i (table_select_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .pos_fast_i     (pos_fast_i),
    .pos_middle_i   (pos_middle_i),
    .pos_slow_i     (pos_slow_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cipher_letter_i(cipher_letter_o),
    .fail_count_o   (fail_count),
    .due_count_o    (due_count)
  );

  // receiver: picks a new random stall style whenever its hold counter runs out
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((cyc % 7) < 4);
    endcase
  end

  task automatic drive_item(input logic [1:0] m, input logic [rce_pkg::SymW-1:0] ltr,
                            input logic [rce_pkg::SelW-1:0] sel,
                            input logic [rce_pkg::SymW-1:0] idx,
                            input logic [rce_pkg::SymW-1:0] val,
                            input logic [rce_pkg::SymW-1:0] pf,
                            input logic [rce_pkg::SymW-1:0] pm,
                            input logic [rce_pkg::SymW-1:0] ps);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    letter_i       <= ltr;
    table_select_i <= sel;
    table_index_i  <= idx;
    table_value_i  <= val;
    pos_fast_i     <= pf;
    pos_middle_i   <= pm;
    pos_slow_i     <= ps;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  function automatic logic [rce_pkg::SymW-1:0] any5();
    return rce_pkg::SymW'($urandom_range(0, 31));
  endfunction

  task automatic encrypt(input logic [rce_pkg::SymW-1:0] ltr);
    drive_item(rce_pkg::ModeEncrypt, ltr, rce_pkg::SelW'($urandom_range(0, 7)), any5(),
               any5(), any5(), any5(), any5());
  endtask

  task automatic set_pos(input logic [rce_pkg::SymW-1:0] pf,
                         input logic [rce_pkg::SymW-1:0] pm,
                         input logic [rce_pkg::SymW-1:0] ps);
    drive_item(rce_pkg::ModeSetPos, any5(), rce_pkg::SelW'($urandom_range(0, 7)), any5(),
               any5(), pf, pm, ps);
  endtask

  task automatic load(input logic [rce_pkg::SelW-1:0] sel,
                      input logic [rce_pkg::SymW-1:0] idx,
                      input logic [rce_pkg::SymW-1:0] val);
    drive_item(rce_pkg::ModeLoad, any5(), sel, idx, val, any5(), any5(), any5());
  endtask

  initial begin
    int                       pick;
    logic [1:0]               m;
    logic [rce_pkg::SymW-1:0] ltr;
    logic [rce_pkg::SelW-1:0] sel;
    logic [rce_pkg::SymW-1:0] idx;
    logic [rce_pkg::SymW-1:0] val;
    logic [rce_pkg::SymW-1:0] pf;
    logic [rce_pkg::SymW-1:0] pm;
    logic [rce_pkg::SymW-1:0] ps;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // every table entry gets written before any letter goes through
    for (int s = 0; s < rce_pkg::NumTables; s++) begin
      for (int i = 0; i < Alpha; i++) begin
        load(rce_pkg::SelW'(s), rce_pkg::SymW'(i), any5());
      end
    end

    encrypt(5'd0);
    encrypt(5'd25);
    encrypt(5'd31);
    set_pos(5'd25, 5'd25, 5'd25);
    encrypt(5'd12);
    set_pos(5'd31, 5'd31, 5'd31);
    encrypt(5'd0);
    set_pos(5'd25, 5'd0, 5'd0);
    encrypt(5'd7);
    set_pos(5'd25, 5'd25, 5'd3);
    encrypt(5'd19);
    load(rce_pkg::TblPlug, 5'd26, 5'd0);
    load(rce_pkg::TblRot0Fwd, 5'd31, 5'd31);
    load(rce_pkg::TblRefl, 5'd0, 5'd31);
    load(rce_pkg::TblPlug, 5'd25, 5'd30);
    encrypt(5'd0);
    encrypt(5'd25);
    drive_item(ModeUnused, any5(), rce_pkg::SelW'($urandom_range(0, 7)), any5(), any5(),
               any5(), any5(), any5());
    encrypt(any5());
    set_pos(5'd0, 5'd0, 5'd0);
    encrypt(5'd26);

    for (int n = 0; n < 1370; n++) begin
      pick = $urandom_range(0, 99);
      ltr  = any5();
      sel  = rce_pkg::SelW'($urandom_range(0, 7));
      idx  = any5();
      val  = any5();
      pf   = any5();
      pm   = any5();
      ps   = any5();
      if (pick < 70) begin
        m = rce_pkg::ModeEncrypt;
        if ($urandom_range(0, 4) != 0) ltr = rce_pkg::SymW'($urandom_range(0, Alpha - 1));
      end else if (pick < 85) begin
        m = rce_pkg::ModeLoad;
        if ($urandom_range(0, 9) != 0) idx = rce_pkg::SymW'($urandom_range(0, Alpha - 1));
      end else if (pick < 93) begin
        m = rce_pkg::ModeSetPos;
        if ($urandom_range(0, 3) == 0) begin
          pf = 5'd25;
          pm = ($urandom_range(0, 1) == 1) ? 5'd25 : pm;
        end
      end else begin
        m = ModeUnused;
      end
      drive_item(m, ltr, sel, idx, val, pf, pm, ps);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

### sim.f
rtl/rce_pkg.sv
rtl/rce_mod_unit.sv
rtl/rce_tbl_mem.sv
rtl/rce_seq.sv
rtl/rotor_cipher_encrypt_top.sv
bench/rce_checker.sv
bench/tb_top.sv
